FILE: rtl/bdr_pkg.sv
// bdr_pkg: shared types, constants and helper functions of the boom direction block
// no dependencies; compiled first
package bdr_pkg;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_BACK_DISTANCE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LIFT_HEIGHT   = 1'd1;

    localparam logic signed [15:0] BACK_RESET = 16'sd1024;
    localparam logic signed [15:0] LIFT_RESET = 16'sd128;

    localparam int ONE_Q14     = 16384;
    localparam int CW          = 34;          // cordic datapath width
    localparam int SQRT_STAGES = 32;          // one root bit per cell
    localparam int DIV_STAGES  = 16;          // one quotient bit per cell
    localparam int DIV_W       = 50;
    localparam int DEN_W       = 34;

    localparam logic signed [CW-1:0] CORDIC_X0 = 34'sd652032874;
    localparam int ATAN_COUNT = 24;

    localparam logic [31:0] ATAN_PHASE [ATAN_COUNT] = '{
        32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
    };

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] z;
        logic                 flip;
    } t_cordic;

    typedef struct packed {
        logic [63:0] v;
        logic [63:0] r;
    } t_sqrt;

    typedef struct packed {
        logic [DIV_W-1:0] rem;
        logic [DEN_W-1:0] den;
        logic [15:0]      q;
    } t_div;

    typedef struct packed {
        logic signed [15:0] fx;
        logic signed [15:0] fy;
        logic signed [15:0] fz;
        logic signed [17:0] ox;
        logic signed [17:0] oy;
        logic signed [17:0] oz;
    } t_side;

    // limit a wide signed value to the unit range in q2.14
    function automatic logic signed [15:0] clamp_unit(input logic signed [39:0] v);
        logic signed [15:0] res;
        if (v > 40'sd16384) begin
            res = 16'sd16384;
        end else if (v < -40'sd16384) begin
            res = -16'sd16384;
        end else begin
            res = v[15:0];
        end
        return res;
    endfunction

    // undo the half-turn fold, round half up from q2.30 to q2.14, clamp
    function automatic logic signed [15:0] cordic_result(input logic signed [CW-1:0] v,
                                                         input logic flip);
        logic signed [CW:0] t;
        logic signed [CW:0] s;
        t = flip ? -(CW+1)'(v) : (CW+1)'(v);
        s = (t + 35'sd32768) >>> 16;
        return clamp_unit(40'(s));
    endfunction

    // round half up of a q4.28 product to q2.14
    function automatic logic signed [17:0] round14(input logic signed [31:0] p);
        logic signed [32:0] s;
        s = (33'(p) + 33'sd8192) >>> 14;
        return s[17:0];
    endfunction

endpackage

FILE: rtl/bdr_in_if.sv
// bdr_in_if: input channel carrying one yaw / pitch angle pair
// no dependencies
interface bdr_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] yaw_angle;
    logic signed [15:0] pitch_angle;

    modport source(output valid, output yaw_angle, output pitch_angle, input ready);
    modport sink(input valid, input yaw_angle, input pitch_angle, output ready);
endinterface

FILE: rtl/bdr_out_if.sv
// bdr_out_if: output channel carrying direction, reach and degenerate flag
// no dependencies
interface bdr_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] dir_x;
    logic signed [15:0] dir_y;
    logic signed [15:0] dir_z;
    logic [16:0]        reach_length;
    logic               degenerate;

    modport source(output valid, output dir_x, output dir_y, output dir_z,
                   output reach_length, output degenerate, input ready);
    modport sink(input valid, input dir_x, input dir_y, input dir_z,
                 input reach_length, input degenerate, output ready);
endinterface

FILE: rtl/bdr_cordic_cell.sv
// bdr_cordic_cell: one rotation step of the sin / cos cordic chain
// depends on bdr_pkg
module bdr_cordic_cell #(
    parameter int IDX = 0
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  bdr_pkg::t_cordic i_d,
    output bdr_pkg::t_cordic o_d
);
    import bdr_pkg::*;

    localparam logic signed [CW-1:0] ANG = CW'(ATAN_PHASE[IDX]);

    t_cordic r_d;
    t_cordic n_d;

    always_comb begin
        n_d = i_d;
        if (i_d.z >= 0) begin
            n_d.x = i_d.x - (i_d.y >>> IDX);
            n_d.y = i_d.y + (i_d.x >>> IDX);
            n_d.z = i_d.z - ANG;
        end else begin
            n_d.x = i_d.x + (i_d.y >>> IDX);
            n_d.y = i_d.y - (i_d.x >>> IDX);
            n_d.z = i_d.z + ANG;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d <= n_d;
        end
    end

    assign o_d = r_d;
endmodule

FILE: rtl/bdr_sqrt_cell.sv
// bdr_sqrt_cell: one digit of the bit-by-bit integer square root
// depends on bdr_pkg
module bdr_sqrt_cell #(
    parameter int IDX = 0
) (
    input  logic           i_clk,
    input  logic           i_en,
    input  bdr_pkg::t_sqrt i_d,
    output bdr_pkg::t_sqrt o_d
);
    import bdr_pkg::*;

    localparam logic [63:0] BIT = 64'd1 << (62 - 2 * IDX);

    t_sqrt       r_d;
    t_sqrt       n_d;
    logic [63:0] w_trial;

    always_comb begin
        w_trial = i_d.r + BIT;
        if (i_d.v >= w_trial) begin
            n_d.v = i_d.v - w_trial;
            n_d.r = (i_d.r >> 1) + BIT;
        end else begin
            n_d.v = i_d.v;
            n_d.r = i_d.r >> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d <= n_d;
        end
    end

    assign o_d = r_d;
endmodule

FILE: rtl/bdr_div_cell.sv
// bdr_div_cell: one quotient bit of the restoring divider
// depends on bdr_pkg
module bdr_div_cell #(
    parameter int SHIFT = 0
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  bdr_pkg::t_div i_d,
    output bdr_pkg::t_div o_d
);
    import bdr_pkg::*;

    t_div             r_d;
    t_div             n_d;
    logic [DIV_W-1:0] w_sub;

    always_comb begin
        n_d   = i_d;
        w_sub = DIV_W'(i_d.den) << SHIFT;
        if (i_d.rem >= w_sub) begin
            n_d.rem      = i_d.rem - w_sub;
            n_d.q[SHIFT] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d <= n_d;
        end
    end

    assign o_d = r_d;
endmodule

FILE: rtl/boom_direction_and_reach.sv
// boom_direction_and_reach: camera boom aim, direction and reach from yaw and pitch
// depends on bdr_pkg, bdr_in_if, bdr_out_if and the cordic, sqrt and divider cells
//
//  channel  dir  transaction carries
//  -------  ---  -----------------------------------------------------
//  i_in     in   yaw_angle, pitch_angle
//  o_out    out  dir_x, dir_y, dir_z, reach_length, degenerate
//  i_cfg    in   write enable, register index, write data (no handshake)
//
//  one transaction per cycle in and out while not stalled; registered stages in order:
//  cordic chain, 7 arithmetic stages, 32 root cells, 16 divider cells, output register
//  the whole pipeline advances together; it stalls only when the output register is full
//  and not taken, and i_in.ready follows that same enable
//  synchronous active-low reset clears the valid chain and output valid, and loads the config registers
module boom_direction_and_reach #(
    parameter int ANGLE_BITS    = 16,
    parameter int CORDIC_STAGES = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    bdr_in_if.sink                           i_in,
    bdr_out_if.source                        o_out,
    input  logic                             i_cfg_we,
    input  logic [bdr_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [bdr_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import bdr_pkg::*;

    localparam int SQ = SQRT_STAGES;
    localparam int DV = DIV_STAGES;
    localparam int L  = CORDIC_STAGES + 7 + SQ + DV;  // registered stages before output
    localparam int SD = 2 + SQ + DV;                  // side line depth

    // pipeline enable: moves whenever the output register can take a value
    logic w_en;
    logic r_ov;
    logic [L-1:0] r_vld;

    assign w_en       = !r_ov || o_out.ready;
    assign i_in.ready = w_en;

    // configuration registers
    logic signed [15:0] r_back;
    logic signed [15:0] r_lift;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_back <= BACK_RESET;
            r_lift <= LIFT_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_BACK_DISTANCE: r_back <= i_cfg_data;
                REG_LIFT_HEIGHT:   r_lift <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[L-2:0], i_in.valid};
        end
    end

    // angle to 32-bit phase: keep the low ANGLE_BITS, pitch sign extended first
    logic [31:0] w_yaw32;
    logic [31:0] w_pitch32;
    logic [31:0] w_phase [2];

    assign w_yaw32    = {16'd0, i_in.yaw_angle};
    assign w_pitch32  = 32'(i_in.pitch_angle);
    assign w_phase[0] = {w_yaw32[ANGLE_BITS-1:0], {(32-ANGLE_BITS){1'b0}}};
    assign w_phase[1] = {w_pitch32[ANGLE_BITS-1:0], {(32-ANGLE_BITS){1'b0}}};

    // two cordic lanes: yaw on lane 0, pitch on lane 1
    t_cordic w_cc [2][CORDIC_STAGES+1];

    for (genvar l = 0; l < 2; l++) begin : g_lane
        logic        w_flip;
        logic [31:0] w_z;

        // second and third quarter: fold by a half turn, negate at the end
        assign w_flip = (w_phase[l][31:30] == 2'd1) || (w_phase[l][31:30] == 2'd2);
        assign w_z    = {w_phase[l][31] ^ w_flip, w_phase[l][30:0]};

        assign w_cc[l][0].x    = CORDIC_X0;
        assign w_cc[l][0].y    = '0;
        assign w_cc[l][0].z    = CW'($signed(w_z));
        assign w_cc[l][0].flip = w_flip;

        for (genvar s = 0; s < CORDIC_STAGES; s++) begin : g_cell
            bdr_cordic_cell #(.IDX(s)) u_cell (
                .i_clk (i_clk),
                .i_en  (w_en),
                .i_d   (w_cc[l][s]),
                .o_d   (w_cc[l][s+1])
            );
        end
    end

    // stage a: sin / cos in q2.14
    logic signed [15:0] r_sy, r_cy, r_sp, r_cp;
    // stage b: products
    logic signed [31:0] r_p0, r_p2;
    logic signed [15:0] r_fyb;
    logic signed [17:0] w_fx_rnd, w_fz_rnd;
    // stage c: forward vector
    logic signed [15:0] r_fx, r_fy, r_fz;
    // stage d: forward times back distance
    logic signed [31:0] r_gx, r_gy, r_gz;
    logic signed [15:0] r_fxd, r_fyd, r_fzd;
    // stage e: offset
    logic signed [17:0] r_ox, r_oy, r_oz;
    logic signed [15:0] r_fxe, r_fye, r_fze;
    // stage f: squares, stage g: sum
    logic [35:0] r_qx, r_qy, r_qz;
    logic [35:0] r_s;
    logic signed [35:0] w_qx, w_qy, w_qz;

    assign w_fx_rnd = round14(r_p0);
    assign w_fz_rnd = round14(r_p2);

    assign w_qx = r_ox * r_ox;
    assign w_qy = r_oy * r_oy;
    assign w_qz = r_oz * r_oz;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_cy  <= cordic_result(w_cc[0][CORDIC_STAGES].x, w_cc[0][CORDIC_STAGES].flip);
            r_sy  <= cordic_result(w_cc[0][CORDIC_STAGES].y, w_cc[0][CORDIC_STAGES].flip);
            r_cp  <= cordic_result(w_cc[1][CORDIC_STAGES].x, w_cc[1][CORDIC_STAGES].flip);
            r_sp  <= cordic_result(w_cc[1][CORDIC_STAGES].y, w_cc[1][CORDIC_STAGES].flip);

            r_p0  <= r_sy * r_cp;
            r_p2  <= r_cy * r_cp;
            r_fyb <= r_sp;

            r_fx  <= w_fx_rnd[15:0];
            r_fy  <= r_fyb;
            r_fz  <= -(w_fz_rnd[15:0]);

            r_gx  <= r_fx * r_back;
            r_gy  <= r_fy * r_back;
            r_gz  <= r_fz * r_back;
            r_fxd <= r_fx;
            r_fyd <= r_fy;
            r_fzd <= r_fz;

            // offset sits behind the view, lift only on y
            r_ox  <= -round14(r_gx);
            r_oy  <= -round14(r_gy) + 18'(r_lift);
            r_oz  <= -round14(r_gz);
            r_fxe <= r_fxd;
            r_fye <= r_fyd;
            r_fze <= r_fzd;

            r_qx  <= w_qx;
            r_qy  <= w_qy;
            r_qz  <= w_qz;

            r_s   <= r_qx + r_qy + r_qz;
        end
    end

    // forward and offset ride alongside the root and divider cells
    t_side r_sd [SD];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sd[0] <= '{fx: r_fxe, fy: r_fye, fz: r_fze, ox: r_ox, oy: r_oy, oz: r_oz};
            for (int k = 1; k < SD; k++) begin
                r_sd[k] <= r_sd[k-1];
            end
        end
    end

    // root of s * 2^28, giving the length with 14 extra fraction bits
    t_sqrt w_sq [SQ+1];

    assign w_sq[0].v = {r_s, 28'd0};
    assign w_sq[0].r = '0;

    for (genvar s = 0; s < SQ; s++) begin : g_sqrt
        bdr_sqrt_cell #(.IDX(s)) u_cell (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_d   (w_sq[s]),
            .o_d   (w_sq[s+1])
        );
    end

    // unit direction: round(|o| * 2^28 / r) as (2 |o| 2^28 + r) / (2 r), three lanes
    logic [32:0]       w_root;
    logic signed [17:0] w_o [3];
    t_div              w_dv [3][DV+1];

    assign w_root = w_sq[SQ].r[32:0];
    assign w_o[0] = r_sd[1+SQ].ox;
    assign w_o[1] = r_sd[1+SQ].oy;
    assign w_o[2] = r_sd[1+SQ].oz;

    for (genvar l = 0; l < 3; l++) begin : g_div
        logic [17:0] w_mag;

        assign w_mag          = w_o[l][17] ? 18'(-w_o[l]) : 18'(w_o[l]);
        assign w_dv[l][0].rem = {3'd0, w_mag, 29'd0} + DIV_W'(w_root);
        assign w_dv[l][0].den = {w_root, 1'b0};
        assign w_dv[l][0].q   = '0;

        for (genvar s = 0; s < DV; s++) begin : g_cell
            bdr_div_cell #(.SHIFT(DV - 1 - s)) u_cell (
                .i_clk (i_clk),
                .i_en  (w_en),
                .i_d   (w_dv[l][s]),
                .o_d   (w_dv[l][s+1])
            );
        end
    end

    // final assembly: sign, clamp, reach saturation, degenerate bypass
    t_side              w_fin;
    logic [32:0]        w_r;
    logic               w_degen;
    logic [18:0]        w_reach;
    logic signed [15:0] w_dir [3];
    logic signed [17:0] w_fo [3];
    logic signed [15:0] w_ff [3];

    assign w_fin   = r_sd[SD-1];
    assign w_r     = w_dv[0][DV].den[DEN_W-1:1];
    assign w_degen = (w_r == '0);
    assign w_reach = w_r[32:14];
    assign w_fo[0] = w_fin.ox;
    assign w_fo[1] = w_fin.oy;
    assign w_fo[2] = w_fin.oz;
    assign w_ff[0] = w_fin.fx;
    assign w_ff[1] = w_fin.fy;
    assign w_ff[2] = w_fin.fz;

    for (genvar l = 0; l < 3; l++) begin : g_dir
        logic signed [39:0] w_q;

        assign w_q      = 40'(w_dv[l][DV].q);
        assign w_dir[l] = w_degen ? -w_ff[l]
                                  : clamp_unit(w_fo[l][17] ? -w_q : w_q);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_en) begin
            r_ov <= r_vld[L-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            o_out.dir_x        <= w_dir[0];
            o_out.dir_y        <= w_dir[1];
            o_out.dir_z        <= w_dir[2];
            o_out.reach_length <= w_degen ? 17'd0
                                : (w_reach > 19'd65536) ? 17'd65536 : w_reach[16:0];
            o_out.degenerate   <= w_degen;
        end
    end

    assign o_out.valid = r_ov;

    // a degenerate result always reports zero reach
    a_degen_reach: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.degenerate) |-> (o_out.reach_length == 17'd0))
        else $error("degenerate result with nonzero reach");

    // a nonzero offset is at least one lsb long
    a_reach_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.degenerate) |-> (o_out.reach_length != 17'd0))
        else $error("regular result with zero reach");

    // direction components stay inside the unit range
    a_dir_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> ((o_out.dir_x <= 16'sd16384) && (o_out.dir_x >= -16'sd16384)
                      && (o_out.dir_y <= 16'sd16384) && (o_out.dir_y >= -16'sd16384)
                      && (o_out.dir_z <= 16'sd16384) && (o_out.dir_z >= -16'sd16384)))
        else $error("direction component out of range");

    // a stalled output keeps the pipeline frozen, so the input is not taken
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.ready) |-> !i_in.ready)
        else $error("input taken while output stalled");

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps
// testbench: self-checking bench for boom_direction_and_reach
// depends on bdr_pkg, bdr_in_if, bdr_out_if and the block itself

module testbench;
    import bdr_pkg::*;

    typedef enum logic [0:0] {ROW_CFG, ROW_ITEM} t_row_op;

    typedef struct packed {
        logic signed [15:0] dx;
        logic signed [15:0] dy;
        logic signed [15:0] dz;
        logic [16:0]        reach;
        logic               degen;
    } t_aim;

    // cfg rows: w0 = register index, w1 = data; item rows: w0 = yaw, w1 = pitch
    typedef struct packed {
        t_row_op     op;
        logic [15:0] w0;
        logic [15:0] w1;
        logic        pinned;
        t_aim        aim;
    } t_row;

    localparam int  DRAIN_CYCLES = 16 + 56 + 10;
    localparam int  N_ROWS       = 24;
    localparam int  N_SEGMENTS   = 7;
    localparam int  SEG_ITEMS    = 200;
    localparam t_aim NO_AIM      = '0;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    bdr_in_if  in_ch();
    bdr_out_if out_ch();

    boom_direction_and_reach DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_ch.sink),
        .o_out      (out_ch.source),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // shadow copy of the two boom registers
    logic signed [15:0] boom_back;
    logic signed [15:0] boom_lift;

    t_aim aim_q[$];
    int   send_idle_pct;
    int   take_idle_pct;
    int   hold_cycles;
    int   mismatches;
    int   aims_checked;
    int   degen_seen;
    int   items_sent;

    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    // fixed atan table of the cordic, full turn = 2^32
    function automatic longint atan_step(input int i);
        longint tbl [16] = '{
            64'h20000000, 64'h12E4051D, 64'h09FB385B, 64'h051111D4,
            64'h028B0D43, 64'h0145D7E1, 64'h00A2F61E, 64'h00517C55,
            64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
            64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D
        };
        return tbl[i];
    endfunction

    function automatic longint rnd_shift(input longint v, input int s);
        return (v + (longint'(1) << (s - 1))) >>> s;
    endfunction

    function automatic longint unit_clamp(input longint v);
        longint res;
        res = v;
        if (v > 16384) res = 16384;
        if (v < -16384) res = -16384;
        return res;
    endfunction

    // sin and cos in q2.14 of a 16-bit binary angle
    task automatic angle_trig(input logic [15:0] ang, output longint sn, output longint cs);
        logic [31:0] phase;
        logic        flip;
        longint      x, y, z, nx;
        phase = {ang, 16'h0000};
        flip  = (phase[31:30] == 2'd1) || (phase[31:30] == 2'd2);
        if (flip) phase = phase + 32'h80000000;
        x = 652032874;
        y = 0;
        z = longint'($signed(phase));
        for (int i = 0; i < 16; i++) begin
            if (z >= 0) begin
                nx = x - (y >>> i);
                y  = y + (x >>> i);
                z  = z - atan_step(i);
            end else begin
                nx = x + (y >>> i);
                y  = y - (x >>> i);
                z  = z + atan_step(i);
            end
            x = nx;
        end
        if (flip) begin
            x = -x;
            y = -y;
        end
        cs = unit_clamp(rnd_shift(x, 16));
        sn = unit_clamp(rnd_shift(y, 16));
    endtask

    function automatic longint unsigned int_root(input longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic logic signed [15:0] unit_quot(input longint o, input longint unsigned r);
        longint unsigned mag;
        longint          q;
        mag = longint'(o < 0 ? -o : o) << 28;
        q   = longint'((2 * mag + r) / (2 * r));
        return 16'(unit_clamp(o < 0 ? -q : q));
    endfunction

    // aim direction and reach of the boom for one yaw / pitch pair
    task automatic boom_aim(input logic [15:0] yaw, input logic [15:0] pitch, output t_aim a);
        longint sy, cy, sp, cp;
        longint fwd[3], off[3];
        longint unsigned sq, r, reach;
        angle_trig(yaw, sy, cy);
        angle_trig(pitch, sp, cp);
        fwd[0] = rnd_shift(sy * cp, 14);
        fwd[1] = sp;
        fwd[2] = -rnd_shift(cy * cp, 14);
        for (int k = 0; k < 3; k++) off[k] = -rnd_shift(fwd[k] * longint'(boom_back), 14);
        off[1] = off[1] + longint'(boom_lift);
        sq = longint'(off[0] * off[0]) + longint'(off[1] * off[1]) + longint'(off[2] * off[2]);
        if (sq == 0) begin
            // offset collapsed: fall back to the reversed view
            a.dx = 16'(-fwd[0]);
            a.dy = 16'(-fwd[1]);
            a.dz = 16'(-fwd[2]);
            a.reach = '0;
            a.degen = 1'b1;
        end else begin
            r     = int_root(sq << 28);
            reach = r >> 14;
            if (reach > 65536) reach = 65536;
            a.dx = unit_quot(off[0], r);
            a.dy = unit_quot(off[1], r);
            a.dz = unit_quot(off[2], r);
            a.reach = 17'(reach);
            a.degen = 1'b0;
        end
    endtask

    // receiver: checks every transaction against the oldest expectation
    always @(posedge i_clk) begin
        t_aim want;
        t_aim got;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got = '{out_ch.dir_x, out_ch.dir_y, out_ch.dir_z,
                    out_ch.reach_length, out_ch.degenerate};
            if (aim_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %p", got);
            end else begin
                want = aim_q.pop_front();
                aims_checked++;
                if (got.degen) degen_seen++;
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %p actual %p", want, got);
                end
            end
        end
        // long hold-off requested by the sender side, counted down here
        if (hold_cycles > 0) begin
            out_ch.ready <= 1'b0;
            hold_cycles--;
        end else begin
            out_ch.ready <= ($urandom_range(99) >= take_idle_pct);
        end
    end

    // one transaction on the input channel; valid stays high for the next one
    task automatic send_pair(input logic [15:0] yaw, input logic [15:0] pitch,
                             input logic pinned, input t_aim pin_aim);
        t_aim a;
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.yaw_angle   <= yaw;
        in_ch.pitch_angle <= pitch;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        boom_aim(yaw, pitch, a);
        aim_q.push_back(pinned ? pin_aim : a);
        items_sent++;
    endtask

    // lower valid and wait until every transaction has come back
    task automatic drain;
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (aim_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        if (idx == REG_BACK_DISTANCE) boom_back = data;
        else boom_lift = data;
    endtask

    // angles near the quadrant edges where the cordic fold matters
    function automatic logic [15:0] pick_angle;
        logic [15:0] corner [8] = '{16'h0000, 16'h4000, 16'h8000, 16'hC000,
                                    16'h0001, 16'hFFFF, 16'h3FFF, 16'h7FFF};
        logic [15:0] res;
        if ($urandom_range(9) == 0) res = corner[$urandom_range(7)];
        else res = 16'($urandom);
        return res;
    endfunction

    // directed rows: reset config first, then collapsed offset, then lift only, then extremes
    t_row dir_rows [N_ROWS] = '{
        '{ROW_ITEM, 16'h0000, 16'h0000, 1'b0, NO_AIM},
        '{ROW_ITEM, 16'h4000, 16'h0000, 1'b0, NO_AIM},
        '{ROW_ITEM, 16'h8000, 16'h0000, 1'b0, NO_AIM},
        '{ROW_ITEM, 16'hC000, 16'h0000, 1'b0, NO_AIM},
        '{ROW_ITEM, 16'hFFFF, 16'h7FFF, 1'b0, NO_AIM},
        '{ROW_ITEM, 16'h0000, 16'h8000, 1'b0, NO_AIM},
        '{ROW_ITEM, 16'h2000, 16'h4000, 1'b0, NO_AIM},
        '{ROW_ITEM, 16'hE000, 16'hC000, 1'b0, NO_AIM},
        // no boom at all: reversed view, zero reach
        '{ROW_CFG, 16'(REG_BACK_DISTANCE), 16'h0000, 1'b0, NO_AIM},
        '{ROW_CFG, 16'(REG_LIFT_HEIGHT), 16'h0000, 1'b0, NO_AIM},
        '{ROW_ITEM, 16'h0000, 16'h0000, 1'b0, NO_AIM},
        '{ROW_ITEM, 16'h1234, 16'hFFFF, 1'b0, NO_AIM},
        // lift only: straight up, reach equals the lift
        '{ROW_CFG, 16'(REG_LIFT_HEIGHT), 16'd128, 1'b0, NO_AIM},
        '{ROW_ITEM, 16'h0000, 16'h0000, 1'b1, '{16'sd0, 16'sd16384, 16'sd0, 17'd128, 1'b0}},
        '{ROW_ITEM, 16'hABCD, 16'h5A5A, 1'b1, '{16'sd0, 16'sd16384, 16'sd0, 17'd128, 1'b0}},
        // register extremes
        '{ROW_CFG, 16'(REG_BACK_DISTANCE), 16'h8000, 1'b0, NO_AIM},
        '{ROW_CFG, 16'(REG_LIFT_HEIGHT), 16'h7FFF, 1'b0, NO_AIM},
        '{ROW_ITEM, 16'h2000, 16'h6000, 1'b0, NO_AIM},
        '{ROW_ITEM, 16'hFFFF, 16'h8000, 1'b0, NO_AIM},
        '{ROW_CFG, 16'(REG_BACK_DISTANCE), 16'h7FFF, 1'b0, NO_AIM},
        '{ROW_CFG, 16'(REG_LIFT_HEIGHT), 16'h8000, 1'b0, NO_AIM},
        '{ROW_ITEM, 16'h5555, 16'hAAAA, 1'b0, NO_AIM},
        '{ROW_ITEM, 16'h0001, 16'h0001, 1'b0, NO_AIM},
        '{ROW_ITEM, 16'hC000, 16'h4000, 1'b0, NO_AIM}
    };

    initial begin
        logic [15:0] seg_back [N_SEGMENTS] = '{16'd1024, 16'h8000, 16'd1, 16'h7FFF,
                                                16'd300, 16'hFF00, 16'd0};
        logic [15:0] seg_lift [N_SEGMENTS] = '{16'd128, 16'h7FFF, 16'd0, 16'h8000,
                                                16'hFFC0, 16'd0, 16'd77};
        t_aim none;
        none           = '0;
        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_idx      = '0;
        i_cfg_data     = '0;
        in_ch.valid    = 1'b0;
        in_ch.yaw_angle   = '0;
        in_ch.pitch_angle = '0;
        send_idle_pct  = 24;
        take_idle_pct  = 71;
        hold_cycles    = 0;
        mismatches     = 0;
        aims_checked   = 0;
        degen_seen     = 0;
        items_sent     = 0;
        boom_back      = BACK_RESET;
        boom_lift      = LIFT_RESET;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[n]) begin
            if (dir_rows[n].op == ROW_CFG) begin
                drain();
                write_reg(CFG_IDX_W'(dir_rows[n].w0), dir_rows[n].w1);
            end else begin
                send_pair(dir_rows[n].w0, dir_rows[n].w1, dir_rows[n].pinned,
                          dir_rows[n].aim);
            end
        end

        // random segments: each one under its own boom setting
        for (int s = 0; s < N_SEGMENTS; s++) begin
            drain();
            write_reg(REG_BACK_DISTANCE, seg_back[s]);
            write_reg(REG_LIFT_HEIGHT, seg_lift[s]);
            send_idle_pct = (s < 2) ? 24 : (s < 4) ? 71 : 0;
            take_idle_pct = (s < 2) ? 71 : (s < 4) ? 24 : 0;
            // receiver stalls long enough for the pipeline to back up
            if (s == 4) hold_cycles = 400;
            for (int k = 0; k < SEG_ITEMS; k++) begin
                send_pair(pick_angle(), pick_angle(), 1'b0, none);
                // one pause until everything is back, mid-segment
                if (s == 5 && k == 100) drain();
            end
        end

        drain();
        $display("sent %0d angle pairs over %0d boom settings, %0d results checked, %0d degenerate",
                 items_sent, N_SEGMENTS + 5, aims_checked, degen_seen);
        $display("mismatches: %0d", mismatches);
        if (mismatches == 0) begin
            $display("PASS boom_direction_and_reach");
        end else begin
            $display("FAIL boom_direction_and_reach");
        end
        $finish;
    end

    // guard against a hung handshake
    initial begin
        #4000000;
        $display("timeout");
        $display("FAIL boom_direction_and_reach");
        $finish;
    end

endmodule
